// ===== hdl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg: shared types, codes and saturation helpers
// Q16.16 data type, item modes, register indexes, sum and product saturation.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
  localparam int REG_INDEX_W = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [DATA_WIDTH:0]   sum_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  typedef enum logic [1:0] {
    MODE_REGULATE     = 2'd0,
    MODE_PRESET_INTEG = 2'd1,
    MODE_PRESET_LAST  = 2'd2,
    MODE_UNUSED       = 2'd3
  } mode_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_UPPER = 3'd3,
    REG_INTEG_LOWER = 3'd4,
    REG_OUT_UPPER   = 3'd5,
    REG_OUT_LOWER   = 3'd6,
    REG_NONE        = 3'd7
  } reg_index_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // one guard bit: overflow when guard and sign disagree
  function automatic data_t sat_sum(sum_t v);
    data_t r;
    if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
      r = v[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic data_t add_sat(data_t a, data_t b);
    return sat_sum(sum_t'(a) + sum_t'(b));
  endfunction

  function automatic data_t sub_sat(data_t a, data_t b);
    return sat_sum(sum_t'(a) - sum_t'(b));
  endfunction

  // fits when all bits above the data sign equal the product sign
  function automatic data_t sat_prod(prod_t v);
    data_t r;
    if ((&v[PROD_WIDTH-1:DATA_WIDTH-1]) || !(|v[PROD_WIDTH-1:DATA_WIDTH-1])) begin
      r = v[DATA_WIDTH-1:0];
    end else begin
      r = v[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hdl/pid_regulator_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_regulator_antiwindup: Q16.16 PID regulator with back-calculation
// P, clamped I with anti-windup feedback, optional D, saturating arithmetic.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+-------------------
//  in      | in_valid in_stall mode value     | to block  | regulate / preset
//  out     | out_valid out_stall control_out  | from blk  | one per regulate
//  config  | wr_en wr_index wr_data           | to block  | register write
//
//  One request per cycle unless a regulate request waits on a stalled result:
//  the input register feeds one PID pass (three parallel multiplies, sums,
//  clamps) into the result register, loaded as the request leaves; integ_acc
//  and last_error (the latter only if deriv_gain != 0) close in that pass.
//  Reset (rst, synchronous) empties both registers, zeroes the state and
//  loads the register defaults. Only a regulate request behind a stalled
//  result waits, and in_stall follows from that; presets always pass.
//
module pid_regulator_antiwindup
  import pid_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic signed [31:0]     value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     control_out,
  // configuration
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [31:0]            wr_data
);

  // floor(a*b / 2^FRAC_BITS) then saturate; >>> on a signed product floors
  function automatic data_t mulq(data_t a, data_t b);
    prod_t prod;
    prod_t shifted;
    prod    = prod_t'(a) * prod_t'(b);
    shifted = prod >>> FRAC_BITS;
    return sat_prod(shifted);
  endfunction

  // configuration registers
  data_t prop_gain, integ_gain, deriv_gain;
  data_t integ_upper, integ_lower, out_upper, out_lower;

  // regulator state
  data_t integ_acc, last_error;

  // input register
  logic  req_valid;
  mode_t req_mode;
  data_t req_value;

  logic  is_regulate, out_free, advance;

  // datapath
  data_t p_term, i_term, d_term, delta;
  data_t integ_sum, integ_clamped, pi_sum, pi_clamped, discharge;
  data_t integ_next, pid_sum, result_next;

  always_comb begin
    is_regulate = (req_mode == MODE_REGULATE);
    out_free    = !out_valid || !out_stall;
    advance     = req_valid && (out_free || !is_regulate);
  end

  assign in_stall = req_valid && !advance;

  always_comb begin
    delta  = sub_sat(req_value, last_error);
    p_term = mulq(prop_gain, req_value);
    i_term = mulq(integ_gain, req_value);
    d_term = mulq(deriv_gain, delta);

    // integral with its own limits, zero when integ_gain is zero; upper test first
    integ_sum = add_sat(integ_acc, i_term);
    if (integ_gain == '0) begin
      integ_clamped = '0;
    end else if (integ_sum > integ_upper) begin
      integ_clamped = integ_upper;
    end else if (integ_sum < integ_lower) begin
      integ_clamped = integ_lower;
    end else begin
      integ_clamped = integ_sum;
    end

    // output clamp; clipped amount is fed back into the integral
    pi_sum = add_sat(p_term, integ_clamped);
    if (pi_sum > out_upper) begin
      discharge  = sub_sat(out_upper, pi_sum);
      pi_clamped = out_upper;
    end else if (pi_sum < out_lower) begin
      discharge  = sub_sat(out_lower, pi_sum);
      pi_clamped = out_lower;
    end else begin
      discharge  = '0;
      pi_clamped = pi_sum;
    end
    integ_next = add_sat(integ_clamped, discharge);

    // derivative path, then clamp again
    pid_sum = add_sat(pi_clamped, d_term);
    if (deriv_gain == '0) begin
      result_next = pi_clamped;
    end else if (pid_sum > out_upper) begin
      result_next = out_upper;
    end else if (pid_sum < out_lower) begin
      result_next = out_lower;
    end else begin
      result_next = pid_sum;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_upper <= DATA_MAX;
      integ_lower <= DATA_MIN;
      out_upper   <= DATA_MAX;
      out_lower   <= DATA_MIN;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_PROP_GAIN:   prop_gain   <= wr_data;
        REG_INTEG_GAIN:  integ_gain  <= wr_data;
        REG_DERIV_GAIN:  deriv_gain  <= wr_data;
        REG_INTEG_UPPER: integ_upper <= wr_data;
        REG_INTEG_LOWER: integ_lower <= wr_data;
        REG_OUT_UPPER:   out_upper   <= wr_data;
        REG_OUT_LOWER:   out_lower   <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_mode  <= mode_t'(mode);
      req_value <= value;
    end
  end

  // state update as the request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc  <= '0;
      last_error <= '0;
    end else if (advance) begin
      case (req_mode)
        MODE_REGULATE: begin
          integ_acc <= integ_next;
          if (deriv_gain != '0) begin
            last_error <= req_value;
          end
        end
        MODE_PRESET_INTEG: integ_acc  <= req_value;
        MODE_PRESET_LAST:  last_error <= req_value;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_regulate) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_regulate) begin
      control_out <= result_next;
    end
  end

endmodule

// ===== hdl/pid_checker.sv =====
// ----------------------------------------------------------------------------
// pid_checker: port-level checks for the PID regulator
// Result hold under stall, reset emptying, request stall coupling.
// ----------------------------------------------------------------------------
module pid_checker
  import pid_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] control_out
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(control_out))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // requests only back up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with result register free");

endmodule

bind pid_regulator_antiwindup pid_checker u_pid_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .control_out (control_out)
);
